// ===== sv/tracker_packet_scheduler_framer_crc8_unit_macros.svh =====
// Assertion helpers for the checker module.
// Each macro expects clk and rst_n in the calling scope.
`ifndef TRACKER_PACKET_SCHEDULER_FRAMER_CRC8_UNIT_MACROS_SVH
`define TRACKER_PACKET_SCHEDULER_FRAMER_CRC8_UNIT_MACROS_SVH

// Same-cycle implication.
`define TPSF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TPSF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tpsf_pkg.sv =====
`timescale 1ns / 1ps
package tpsf_pkg;

    localparam int PKT_LEN      = 12;
    localparam int PKT_BODY_LEN = PKT_LEN - 1;

    localparam logic [3:0] LAST_IDX = 4'(PKT_LEN - 1);

    localparam logic [7:0] CRC_POLY      = 8'h07;
    localparam logic [7:0] CRC_INIT      = 8'hFF;
    localparam logic [7:0] IMU_CODE      = 8'h45;
    localparam logic [7:0] INFO_VERSION  = 8'h01;
    localparam logic [7:0] STATUS_ACTIVE = 8'h01;
    localparam logic [11:0] AZ_MAX       = 12'h7FF;
    localparam logic [11:0] AZ_MIN       = 12'h800;
    localparam logic [3:0] BATT_MAX      = 4'd15;

    localparam logic [7:0]  RATE_DIV_RESET    = 8'd1;
    localparam logic [7:0]  INFO_PER_RESET    = 8'd200;
    localparam logic [7:0]  STATUS_PER_RESET  = 8'd100;

    // packet kinds
    localparam logic [1:0] KIND_ORIENT = 2'd0;
    localparam logic [1:0] KIND_INFO   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // config register indexes
    localparam logic [1:0] CFG_RATE_DIV   = 2'd0;
    localparam logic [1:0] CFG_INFO_PER   = 2'd1;
    localparam logic [1:0] CFG_STATUS_PER = 2'd2;
    localparam logic [1:0] CFG_DEVICE_UID = 2'd3;

    typedef struct packed {
        logic [1:0]                         kind;
        logic [PKT_BODY_LEN-1:0][7:0]       body;   // bytes 0..10, header first
    } tpsf_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tpsf_q_stat_t;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_PUSH
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_SEND
    } back_state_t;

    // One restoring-division step: shift in one dividend bit, subtract if it fits.
    function automatic logic [7:0] rem_step(input logic [7:0] rem, input logic b,
                                            input logic [7:0] d);
        logic [8:0] r;
        r = {rem, b};
        if (r >= {1'b0, d})
            r = r - {1'b0, d};
        return r[7:0];
    endfunction

    // CRC-8, MSB first, one data byte.
    function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] d);
        logic [7:0] x;
        x = c ^ d;
        for (int i = 0; i < 8; i++)
        begin
            if (x[7])
                x = {x[6:0], 1'b0} ^ CRC_POLY;
            else
                x = {x[6:0], 1'b0};
        end
        return x;
    endfunction

endpackage

// ===== sv/tpsf_sample_if.sv =====
`timescale 1ns / 1ps
interface tpsf_sample_if;
    logic              valid;
    logic              ready;
    logic [5:0]        trk_id;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] accel_z;
    logic [6:0]        batt_pct;
    logic [15:0]       batt_mv;
    logic signed [7:0] temp_c;

    modport source (
        output valid, trk_id, quat_w, quat_x, quat_y, quat_z, accel_z,
               batt_pct, batt_mv, temp_c,
        input  ready
    );
    modport sink (
        input  valid, trk_id, quat_w, quat_x, quat_y, quat_z, accel_z,
               batt_pct, batt_mv, temp_c,
        output ready
    );
endinterface

// ===== sv/tpsf_byte_if.sv =====
`timescale 1ns / 1ps
interface tpsf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] pkt_byte;
    logic [3:0] byte_index;
    logic       last_byte;
    logic [1:0] packet_kind;

    modport source (
        output valid, pkt_byte, byte_index, last_byte, packet_kind,
        input  ready
    );
    modport sink (
        input  valid, pkt_byte, byte_index, last_byte, packet_kind,
        output ready
    );
endinterface

// ===== sv/tpsf_front.sv =====
`timescale 1ns / 1ps
module tpsf_front
    import tpsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tpsf_sample_if.sink  smp,
    input  logic [7:0]   rate_div,
    input  logic [7:0]   info_per,
    input  logic [7:0]   status_per,
    input  logic [31:0]  device_uid,
    input  tpsf_q_stat_t q_stat,
    output logic         push,
    output tpsf_job_t    job
);

    front_state_t state_reg, state_next;
    logic [7:0]   cnt_reg, cnt_next;
    logic [2:0]   step_reg, step_next;
    logic [7:0]   rem_rate_reg, rem_info_reg, rem_stat_reg;

    // latched sample (payload, no reset)
    logic [5:0]   id_reg;
    logic [15:0]  qw_reg, qx_reg, qy_reg, qz_reg;
    logic [11:0]  az_reg;
    logic [3:0]   bp_reg;
    logic [15:0]  mv_reg;
    logic [7:0]   temp_reg;

    logic         accept;
    logic         send;
    logic         is_info, is_status;
    logic [1:0]   kind;
    logic [15:0]  half_az;
    logic [11:0]  az_sat;
    logic [3:0]   bp_sat;

    assign smp.ready = (state_reg == FR_IDLE);
    assign accept    = smp.valid && smp.ready;

    // accel halved (floor) and clamped to 12 bits
    assign half_az = smp.accel_z >>> 1;
    always_comb
    begin
        if (half_az[15:11] == 5'b00000 || half_az[15:11] == 5'b11111)
            az_sat = half_az[11:0];
        else if (half_az[15])
            az_sat = AZ_MIN;
        else
            az_sat = AZ_MAX;
    end
    assign bp_sat = smp.batt_pct[6] ? BATT_MAX : smp.batt_pct[5:2];

    // classification from remainders
    assign send      = (rem_rate_reg == 8'd0);
    assign is_info   = (info_per != 8'd0) && (rem_info_reg == 8'd0);
    assign is_status = (status_per != 8'd0) && (rem_stat_reg == 8'd0);
    assign kind      = is_info ? KIND_INFO : (is_status ? KIND_STATUS : KIND_ORIENT);

    always_comb
    begin
        job.kind = kind;
        job.body = '0;
        job.body[0] = {kind, id_reg};
        unique case (kind)
            KIND_INFO:
            begin
                job.body[1] = IMU_CODE;
                job.body[2] = INFO_VERSION;
                job.body[4] = INFO_VERSION;
                job.body[6] = device_uid[7:0];
                job.body[7] = device_uid[15:8];
                job.body[8] = device_uid[23:16];
                job.body[9] = device_uid[31:24];
            end
            KIND_STATUS:
            begin
                job.body[1] = STATUS_ACTIVE;
                job.body[2] = mv_reg[7:0];
                job.body[3] = mv_reg[15:8];
                job.body[4] = temp_reg;
            end
            default:
            begin
                job.body[1]  = qw_reg[7:0];
                job.body[2]  = qw_reg[15:8];
                job.body[3]  = qx_reg[7:0];
                job.body[4]  = qx_reg[15:8];
                job.body[5]  = qy_reg[7:0];
                job.body[6]  = qy_reg[15:8];
                job.body[7]  = qz_reg[7:0];
                job.body[8]  = qz_reg[15:8];
                job.body[9]  = az_reg[7:0];
                job.body[10] = {bp_reg, az_reg[11:8]};
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        push       = 1'b0;
        unique case (state_reg)
            FR_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = cnt_reg + 8'd1;
                    step_next  = 3'd7;
                    state_next = FR_DIV;
                end
            end
            FR_DIV:
            begin
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                    state_next = FR_PUSH;
            end
            FR_PUSH:
            begin
                if (!send)
                    state_next = FR_IDLE;
                else if (!q_stat.full)
                begin
                    push       = 1'b1;
                    state_next = FR_IDLE;
                end
            end
            default: state_next = FR_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_IDLE;
            cnt_reg   <= 8'd0;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

    // remainder datapath: one dividend bit per cycle, three divisors in parallel
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rem_rate_reg <= 8'd0;
            rem_info_reg <= 8'd0;
            rem_stat_reg <= 8'd0;
        end
        else if (state_reg == FR_DIV)
        begin
            rem_rate_reg <= rem_step(rem_rate_reg, cnt_reg[step_reg], rate_div);
            rem_info_reg <= rem_step(rem_info_reg, cnt_reg[step_reg], info_per);
            rem_stat_reg <= rem_step(rem_stat_reg, cnt_reg[step_reg], status_per);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg   <= smp.trk_id;
            qw_reg   <= smp.quat_w;
            qx_reg   <= smp.quat_x;
            qy_reg   <= smp.quat_y;
            qz_reg   <= smp.quat_z;
            az_reg   <= az_sat;
            bp_reg   <= bp_sat;
            mv_reg   <= smp.batt_mv;
            temp_reg <= smp.temp_c;
        end
    end

endmodule

// ===== sv/tpsf_queue.sv =====
`timescale 1ns / 1ps
module tpsf_queue
    import tpsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  tpsf_job_t    push_data,
    input  logic         pop,
    output tpsf_job_t    pop_data,
    output tpsf_q_stat_t stat
);

    tpsf_job_t  mem[2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign stat.full  = (cnt_reg == 2'd2);
    assign stat.empty = (cnt_reg == 2'd0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== sv/tpsf_back.sv =====
`timescale 1ns / 1ps
module tpsf_back
    import tpsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  tpsf_q_stat_t q_stat,
    input  tpsf_job_t    q_data,
    output logic         pop,
    tpsf_byte_if.source  out
);

    back_state_t state_reg, state_next;
    tpsf_job_t   job_reg;
    logic [3:0]  idx_reg;
    logic [7:0]  crc_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic [3:0]  out_idx_reg;
    logic        out_last_reg;
    logic [1:0]  out_kind_reg;

    logic        can_emit, emit, load;
    logic        at_last;
    logic [7:0]  cur_byte;

    assign out.valid       = out_valid_reg;
    assign out.pkt_byte    = out_byte_reg;
    assign out.byte_index  = out_idx_reg;
    assign out.last_byte   = out_last_reg;
    assign out.packet_kind = out_kind_reg;

    assign can_emit = !out_valid_reg || out.ready;
    assign at_last  = (idx_reg == LAST_IDX);
    assign cur_byte = at_last ? crc_reg : job_reg.body[idx_reg];

    always_comb
    begin
        state_next     = state_reg;
        emit           = 1'b0;
        load           = 1'b0;
        out_valid_next = out_valid_reg && !out.ready;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    load       = 1'b1;
                    state_next = BK_SEND;
                end
            end
            BK_SEND:
            begin
                if (can_emit)
                begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    if (at_last)
                    begin
                        // chain straight into the next queued packet
                        load       = !q_stat.empty;
                        state_next = q_stat.empty ? BK_IDLE : BK_SEND;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            crc_reg       <= CRC_INIT;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load)
            begin
                idx_reg <= 4'd0;
                crc_reg <= CRC_INIT;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 4'd1;
                crc_reg <= crc8_byte(crc_reg, cur_byte);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            job_reg <= q_data;
        if (emit)
        begin
            out_byte_reg <= cur_byte;
            out_idx_reg  <= idx_reg;
            out_last_reg <= at_last;
            out_kind_reg <= job_reg.kind;
        end
    end

endmodule

// ===== sv/tracker_packet_scheduler_framer_crc8_unit.sv =====
`timescale 1ns / 1ps
// Sensor-sample packet framer with CRC-8 (poly 0x07, init 0xFF).
// sample_ch (valid/ready) takes one sensor sample per word. Each sample bumps
//   an 8-bit wrapping counter; when the count is a multiple of the send
//   divider a 12-byte packet (info, status or orientation) is built.
// byte_ch (valid/ready) delivers that packet one byte per word, index 0..11,
//   last_byte set on the trailing CRC byte.
// Config: cfg_we/cfg_index/cfg_data write the send divider, info_period,
//   status_period and device_uid; write only while the block is idle.
// Front: accept, 8 restoring-remainder steps for the three divisors in
//   parallel, then classify and queue push; no new sample is taken until done.
// Back: one byte a cycle through the output register while byte_ch is not stalled,
//   CRC updated one byte per cycle. A 2-entry packet queue sits between them.
// Reset: counter 0, send divider 1, info_period 200, status_period 100,
//   device_uid 0, queue and output empty.
// Stall: a stalled byte_ch holds its word; the back stops, the queue fills,
//   then the front holds its packet and sample_ch.ready stays low.
module tracker_packet_scheduler_framer_crc8_unit
    import tpsf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tpsf_sample_if.sink  sample_ch,
    tpsf_byte_if.source  byte_ch,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    logic [7:0]   rate_div_reg;
    logic [7:0]   info_per_reg;
    logic [7:0]   status_per_reg;
    logic [31:0]  uid_reg;

    tpsf_q_stat_t q_stat;
    tpsf_job_t    push_job, pop_job;
    logic         push, pop;

    // Config registers; a zero send divider is stored as one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_div_reg   <= RATE_DIV_RESET;
            info_per_reg   <= INFO_PER_RESET;
            status_per_reg <= STATUS_PER_RESET;
            uid_reg        <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RATE_DIV:
                    rate_div_reg <= (cfg_data[7:0] == 8'd0) ? RATE_DIV_RESET : cfg_data[7:0];
                CFG_INFO_PER:   info_per_reg   <= cfg_data[7:0];
                CFG_STATUS_PER: status_per_reg <= cfg_data[7:0];
                CFG_DEVICE_UID: uid_reg        <= cfg_data;
            endcase
        end
    end

    // Front: count, divide, classify, assemble the 11 header/body bytes.
    tpsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .smp        (sample_ch),
        .rate_div   (rate_div_reg),
        .info_per   (info_per_reg),
        .status_per (status_per_reg),
        .device_uid (uid_reg),
        .q_stat     (q_stat),
        .push       (push),
        .job        (push_job)
    );

    // Packet queue decoupling front and back.
    tpsf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .stat      (q_stat)
    );

    // Back: serialize bytes and append the CRC.
    tpsf_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .q_data (pop_job),
        .pop    (pop),
        .out    (byte_ch)
    );

endmodule

// ===== sv/tpsf_checker.sv =====
`timescale 1ns / 1ps
`include "tracker_packet_scheduler_framer_crc8_unit_macros.svh"
module tpsf_checker
    import tpsf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] pkt_byte,
    input logic [3:0] byte_index,
    input logic       last_byte,
    input logic [1:0] packet_kind
);

    logic [3:0] exp_idx_reg, exp_idx_next;
    logic [1:0] kind_reg;
    logic       taken;

    assign taken        = out_valid && out_ready;
    assign exp_idx_next = last_byte ? 4'd0 : byte_index + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= 4'd0;
            kind_reg    <= KIND_ORIENT;
        end
        else if (taken)
        begin
            exp_idx_reg <= exp_idx_next;
            kind_reg    <= packet_kind;
        end
    end

    `TPSF_ASSERT_NOW(a_idx_seq, out_valid, byte_index == exp_idx_reg,
        "byte index out of sequence")
    `TPSF_ASSERT_NOW(a_last_crc, out_valid, last_byte == (byte_index == LAST_IDX),
        "last flag misplaced")
    `TPSF_ASSERT_NOW(a_kind_held, out_valid && byte_index != 4'd0, packet_kind == kind_reg,
        "kind changed in packet")
    `TPSF_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
        out_valid && $stable(pkt_byte) && $stable(byte_index), "stalled word changed")

endmodule

bind tracker_packet_scheduler_framer_crc8_unit tpsf_checker u_tpsf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (byte_ch.valid),
    .out_ready   (byte_ch.ready),
    .pkt_byte    (byte_ch.pkt_byte),
    .byte_index  (byte_ch.byte_index),
    .last_byte   (byte_ch.last_byte),
    .packet_kind (byte_ch.packet_kind)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import tpsf_pkg::*;

    // Pause after the last expected word before a register write or the end:
    // covers the front's division steps plus the 12-byte back with some margin.
    localparam int DRAIN_CYCLES = 40;
    // Long receiver hold-off, long enough to fill the packet queue.
    localparam int HOLD_CYCLES  = 300;
    // Cycles with no sample taken and no expected byte taken before the run is stopped.
    localparam int WDOG_LIMIT   = 3000;

    typedef struct {
        logic [5:0]         trk_id;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] accel_z;
        logic [6:0]         batt_pct;
        logic [15:0]        batt_mv;
        logic signed [7:0]  temp_c;
    } sample_t;

    typedef struct {
        logic [7:0] pkt_byte;
        logic [3:0] byte_index;
        logic       last_byte;
        logic [1:0] packet_kind;
    } pkt_word_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    tpsf_sample_if smp_if();
    tpsf_byte_if   byte_if();

    tracker_packet_scheduler_framer_crc8_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (smp_if),
        .byte_ch   (byte_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow copy of the block's registers and sample counter.
    logic [7:0]  sh_rate_div   = RATE_DIV_RESET;
    logic [7:0]  sh_info_per   = INFO_PER_RESET;
    logic [7:0]  sh_status_per = STATUS_PER_RESET;
    logic [31:0] sh_uid        = '0;
    logic [7:0]  smp_count     = '0;

    sample_t   sample_q[$];       // samples waiting to be offered
    pkt_word_t byte_expect_q[$];  // packet bytes predicted, oldest first

    // Traffic shaping, set by the sequence below.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic send_hold      = 1'b0;  // sender stops offering new words
    logic hold_on        = 1'b0;  // receiver does one long hold-off
    int   hold_cnt       = 0;
    int   err_cnt        = 0;
    int   idle_cnt       = 0;

    task automatic report(string what);
        $display("MISMATCH at %0t ns: %s", $realtime, what);
        err_cnt++;
    endtask

    // CRC-8, poly 0x07, MSB first, no reflection.
    function automatic logic [7:0] crc8_next(logic [7:0] c, logic [7:0] d);
        logic [7:0] x;
        x = c ^ d;
        for (int i = 0; i < 8; i++)
        begin
            x = x[7] ? ({x[6:0], 1'b0} ^ CRC_POLY) : {x[6:0], 1'b0};
        end
        return x;
    endfunction

    // Bumps the counter and, on a send count, queues the 12 expected bytes.
    task automatic frame_sample(sample_t s);
        logic [7:0]         body [PKT_LEN];
        logic [1:0]         kind;
        logic signed [15:0] half;
        logic [11:0]        az;
        logic [4:0]         bp;
        logic [7:0]         crc;
        pkt_word_t          w;
        smp_count = smp_count + 8'd1;
        if (smp_count % sh_rate_div != 8'd0)
        begin
            return;
        end
        foreach (body[k])
        begin
            body[k] = 8'h00;
        end
        // Info wins over status when both periods match; zero disables a kind.
        if (sh_info_per != 8'd0 && smp_count % sh_info_per == 8'd0)
        begin
            kind    = KIND_INFO;
            body[1] = IMU_CODE;
            body[2] = INFO_VERSION;
            body[4] = 8'h01;
            body[6] = sh_uid[7:0];
            body[7] = sh_uid[15:8];
            body[8] = sh_uid[23:16];
            body[9] = sh_uid[31:24];
        end
        else if (sh_status_per != 8'd0 && smp_count % sh_status_per == 8'd0)
        begin
            kind    = KIND_STATUS;
            body[1] = STATUS_ACTIVE;
            body[2] = s.batt_mv[7:0];
            body[3] = s.batt_mv[15:8];
            body[4] = s.temp_c;
        end
        else
        begin
            kind    = KIND_ORIENT;
            body[1] = s.quat_w[7:0];
            body[2] = s.quat_w[15:8];
            body[3] = s.quat_x[7:0];
            body[4] = s.quat_x[15:8];
            body[5] = s.quat_y[7:0];
            body[6] = s.quat_y[15:8];
            body[7] = s.quat_z[7:0];
            body[8] = s.quat_z[15:8];
            // floor(accel / 2), clamped to 12-bit signed
            half = s.accel_z >>> 1;
            if (half > 2047)
            begin
                half = 2047;
            end
            else if (half < -2048)
            begin
                half = -2048;
            end
            az = half[11:0];
            bp = s.batt_pct[6:2];
            if (bp > 5'd15)
            begin
                bp = 5'd15;
            end
            body[9]  = az[7:0];
            body[10] = {bp[3:0], az[11:8]};
        end
        body[0] = {kind, s.trk_id};
        crc = CRC_INIT;
        for (int k = 0; k < PKT_LEN - 1; k++)
        begin
            crc = crc8_next(crc, body[k]);
        end
        body[PKT_LEN-1] = crc;
        for (int k = 0; k < PKT_LEN; k++)
        begin
            w.pkt_byte    = body[k];
            w.byte_index  = 4'(k);
            w.last_byte   = (k == PKT_LEN - 1);
            w.packet_kind = kind;
            byte_expect_q.push_back(w);
        end
    endtask

    // ---------------------------------------------------------------------
    // Sample driver: a word stays up until taken; a new one is picked only
    // after the previous one moved or the channel was idle.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        sample_t s;
        if (!rst_n)
        begin
            smp_if.valid <= 1'b0;
        end
        else if (!smp_if.valid || smp_if.ready)
        begin
            if (sample_q.size() != 0 && !send_hold &&
                $urandom_range(99) >= send_idle_pct)
            begin
                s = sample_q.pop_front();
                smp_if.valid    <= 1'b1;
                smp_if.trk_id   <= s.trk_id;
                smp_if.quat_w   <= s.quat_w;
                smp_if.quat_x   <= s.quat_x;
                smp_if.quat_y   <= s.quat_y;
                smp_if.quat_z   <= s.quat_z;
                smp_if.accel_z  <= s.accel_z;
                smp_if.batt_pct <= s.batt_pct;
                smp_if.batt_mv  <= s.batt_mv;
                smp_if.temp_c   <= s.temp_c;
            end
            else
            begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Byte receiver: random stalls, plus one long hold-off counted here so
    // the packet queue fills and sample_ch backs up.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_if.ready <= 1'b0;
            hold_cnt      <= 0;
        end
        else if (hold_on && hold_cnt < HOLD_CYCLES)
        begin
            byte_if.ready <= 1'b0;
            hold_cnt      <= hold_cnt + 1;
        end
        else
        begin
            byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            if (!hold_on)
            begin
                hold_cnt <= 0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: check each byte word against the oldest prediction, then
    // predict from any sample word taken at this edge.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        pkt_word_t exp_w;
        if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
            begin
                if (byte_expect_q.size() == 0)
                begin
                    report($sformatf("unexpected byte word %h index %0d",
                                     byte_if.pkt_byte, byte_if.byte_index));
                end
                else
                begin
                    exp_w = byte_expect_q.pop_front();
                    if (byte_if.pkt_byte !== exp_w.pkt_byte)
                        report($sformatf("pkt_byte %h, expected %h (index %0d)",
                                         byte_if.pkt_byte, exp_w.pkt_byte,
                                         exp_w.byte_index));
                    if (byte_if.byte_index !== exp_w.byte_index)
                        report($sformatf("byte_index %0d, expected %0d",
                                         byte_if.byte_index, exp_w.byte_index));
                    if (byte_if.last_byte !== exp_w.last_byte)
                        report($sformatf("last_byte %b, expected %b (index %0d)",
                                         byte_if.last_byte, exp_w.last_byte,
                                         exp_w.byte_index));
                    if (byte_if.packet_kind !== exp_w.packet_kind)
                        report($sformatf("packet_kind %0d, expected %0d (index %0d)",
                                         byte_if.packet_kind, exp_w.packet_kind,
                                         exp_w.byte_index));
                end
            end
            if (smp_if.valid && smp_if.ready)
            begin
                frame_sample('{smp_if.trk_id, smp_if.quat_w, smp_if.quat_x,
                               smp_if.quat_y, smp_if.quat_z, smp_if.accel_z,
                               smp_if.batt_pct, smp_if.batt_mv,
                               smp_if.temp_c});
            end
        end
    end

    // Watchdog: no sample taken and no expected byte taken for too long
    // means a hang or a runaway output.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp_if.valid && smp_if.ready) ||
                (byte_if.valid && byte_if.ready && byte_expect_q.size() != 0))
            begin
                idle_cnt <= 0;
            end
            else if (idle_cnt >= WDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            else
            begin
                idle_cnt <= idle_cnt + 1;
            end
        end
    end

    // Register write; the shadow follows at once since the block is idle.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_RATE_DIV:   sh_rate_div   = (val[7:0] == 8'd0) ? 8'd1 : val[7:0];
            CFG_INFO_PER:   sh_info_per   = val[7:0];
            CFG_STATUS_PER: sh_status_per = val[7:0];
            CFG_DEVICE_UID: sh_uid        = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait for all stimulus taken and all bytes seen, then let the front
    // finish any sample that makes no packet.
    task automatic settle();
        while (sample_q.size() != 0 || smp_if.valid || byte_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic sample_t make_sample(int id, int w, int x, int y, int z,
                                            int acc, int pct, int mv, int t);
        sample_t s;
        s.trk_id   = 6'(id);
        s.quat_w   = 16'(w);
        s.quat_x   = 16'(x);
        s.quat_y   = 16'(y);
        s.quat_z   = 16'(z);
        s.accel_z  = 16'(acc);
        s.batt_pct = 7'(pct);
        s.batt_mv  = 16'(mv);
        s.temp_c   = 8'(t);
        return s;
    endfunction

    // Full-range value with the extremes showing up often.
    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic sample_t rand_sample();
        sample_t s;
        s.trk_id = 6'($urandom);
        s.quat_w = pick16();
        s.quat_x = pick16();
        s.quat_y = pick16();
        s.quat_z = pick16();
        // partly around the clamp edges, so both clamped and plain values occur
        case ($urandom_range(2))
            0:       s.accel_z = 16'($urandom_range(8200)) - 16'd4100;
            1:       s.accel_z = pick16();
            default: s.accel_z = 16'($urandom);
        endcase
        // percent above 100 now and then; the nibble clamps at 15
        s.batt_pct = ($urandom_range(7) == 0) ? 7'($urandom_range(127, 101))
                                              : 7'($urandom_range(100));
        s.batt_mv  = 16'($urandom);
        s.temp_c   = 8'($urandom);
        return s;
    endfunction

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------
    initial
    begin
        smp_if.valid    = 1'b0;
        smp_if.trk_id   = '0;
        smp_if.quat_w   = '0;
        smp_if.quat_x   = '0;
        smp_if.quat_y   = '0;
        smp_if.quat_z   = '0;
        smp_if.accel_z  = '0;
        smp_if.batt_pct = '0;
        smp_if.batt_mv  = '0;
        smp_if.temp_c   = '0;
        byte_if.ready   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: info every 5, status every 3, so all kinds show up and
        // count 15 hits both (info wins). Field extremes and clamp edges.
        write_reg(CFG_RATE_DIV, 32'd1);
        write_reg(CFG_INFO_PER, 32'd5);
        write_reg(CFG_STATUS_PER, 32'd3);
        write_reg(CFG_DEVICE_UID, 32'hA5C3_0F96);
        sample_q.push_back(make_sample(0, 32767, -32768, 0, -1, 32767, 127, 0, -128));
        sample_q.push_back(make_sample(63, -32768, 32767, 1, -2, -32768, 100, 65535, 127));
        sample_q.push_back(make_sample(21, 5, 6, 7, 8, 9, 50, 65535, -128));
        sample_q.push_back(make_sample(42, 256, -256, 255, -255, -1, 3, 1, 1));
        sample_q.push_back(make_sample(63, 0, 0, 0, 0, 0, 0, 0, 0));
        sample_q.push_back(make_sample(1, 1, 2, 3, 4, 5, 6, 0, 127));
        sample_q.push_back(make_sample(2, -1, -1, -1, -1, 4095, 4, 77, 0));
        sample_q.push_back(make_sample(3, 12345, -12345, 321, -321, 4096, 63, 9, 9));
        sample_q.push_back(make_sample(4, 0, 0, 0, 0, 0, 0, 16'h1234, -1));
        sample_q.push_back(make_sample(0, 1, 1, 1, 1, 1, 1, 1, 1));
        sample_q.push_back(make_sample(5, 100, 200, 300, 400, -4096, 99, 0, 0));
        sample_q.push_back(make_sample(6, 0, 0, 0, 0, 0, 0, 16'hABCD, 64));
        sample_q.push_back(make_sample(7, -100, -200, -300, -400, -4098, 0, 0, 0));
        sample_q.push_back(make_sample(8, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 1, 101,
                                       0, 0));
        sample_q.push_back(make_sample(9, 0, 0, 0, 0, 0, 0, 0, 0));
        sample_q.push_back(make_sample(10, 7, 7, 7, 7, -3, 64, 0, 0));
        sample_q.push_back(make_sample(11, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                       16'h5555, 85, 0, 0));
        sample_q.push_back(make_sample(12, 0, 0, 0, 0, 0, 0, 16'h8001, -127));
        sample_q.push_back(make_sample(13, 2, 4, 8, 16, 2, 2, 0, 0));
        sample_q.push_back(make_sample(14, 0, 0, 0, 0, 0, 0, 0, 0));
        settle();

        // Both periods zero: orientation only. No idling; midway the sender
        // stops until every predicted byte has arrived.
        write_reg(CFG_RATE_DIV, 32'd0);
        write_reg(CFG_INFO_PER, 32'd0);
        write_reg(CFG_STATUS_PER, 32'd0);
        write_reg(CFG_DEVICE_UID, 32'hFFFF_FFFF);
        repeat (20) sample_q.push_back(rand_sample());
        while (sample_q.size() > 10)
        begin
            @(posedge clk);
        end
        send_hold <= 1'b1;
        @(posedge clk);
        while (smp_if.valid || byte_expect_q.size() != 0)
        begin
            @(posedge clk);
        end
        send_hold <= 1'b0;
        settle();

        // Every other sample sends; sender idles 45 of 100 and the receiver
        // opens with a long hold-off so the queue fills up.
        write_reg(CFG_RATE_DIV, 32'd2);
        write_reg(CFG_INFO_PER, 32'd7);
        write_reg(CFG_STATUS_PER, 32'd4);
        write_reg(CFG_DEVICE_UID, $urandom);
        send_idle_pct <= 45;
        hold_on       <= 1'b1;
        repeat (25) sample_q.push_back(rand_sample());
        settle();
        hold_on <= 1'b0;

        // Status every sent packet bar info at 255; receiver stalls 45.
        write_reg(CFG_RATE_DIV, 32'd3);
        write_reg(CFG_INFO_PER, 32'd255);
        write_reg(CFG_STATUS_PER, 32'd1);
        write_reg(CFG_DEVICE_UID, 32'd0);
        send_idle_pct  <= 0;
        recv_stall_pct <= 45;
        repeat (20) sample_q.push_back(rand_sample());
        settle();

        // Every sample sends, info every 9, status every 5; both sides idle 28.
        write_reg(CFG_RATE_DIV, 32'd1);
        write_reg(CFG_INFO_PER, 32'd9);
        write_reg(CFG_STATUS_PER, 32'd5);
        write_reg(CFG_DEVICE_UID, $urandom);
        send_idle_pct  <= 28;
        recv_stall_pct <= 28;
        repeat (15) sample_q.push_back(rand_sample());
        settle();

        if (err_cnt == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tpsf_pkg.sv
sv/tpsf_sample_if.sv
sv/tpsf_byte_if.sv
sv/tpsf_front.sv
sv/tpsf_queue.sv
sv/tpsf_back.sv
sv/tracker_packet_scheduler_framer_crc8_unit.sv
sv/tpsf_checker.sv
dv/tb_top.sv
